/* rtl/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the top-k index selector: beat payloads,
// register map, and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package tks_pkg;

   localparam int SCORE_FIELD_BITS = 32;
   localparam int KEPT_INDEX_BITS  = 6;
   localparam int KEEP_COUNT_BITS  = 7;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_REG_BITS  = 1;

   // register index codes (byte address / 4)
   localparam logic [CSR_REG_BITS-1:0] REG_KEEP_COUNT = 1'b0;

   localparam logic [KEEP_COUNT_BITS-1:0] KEEP_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic [SCORE_FIELD_BITS-1:0] score;
      logic                        last_score;
   } req_payload_type;

   typedef struct packed {
      logic [KEPT_INDEX_BITS-1:0] kept_index;
      logic                       last_kept;
   } rsp_payload_type;

   typedef struct packed {
      logic load;       // store accepted score
      logic clear_vec;  // vector finished, restart loading at entry 0
      logic scan_first; // start the index scan
      logic scan_next;  // move to the next index
      logic rd_pivot;   // read the scanned entry
      logic cap_pivot;  // capture scanned entry, start the compare sweep
      logic sweep;      // compare one entry against the pivot
      logic emit;       // load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_fire;
      logic req_last;
      logic keep_zero;
      logic keep_all;
      logic keep_hit;
      logic last_scan;
      logic last_cmp;
      logic out_free;
   } ctrl_status_type;

endpackage

/* rtl/tks_ram.sv */
// ----------------------------------------------------------------------------
// tks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tks_ctrl.sv */
// ----------------------------------------------------------------------------
// tks_ctrl
// Sequencer for the top-k selector: load, per-index rank sweep, emit.
// ----------------------------------------------------------------------------
module tks_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  tks_pkg::ctrl_status_type status,
   output tks_pkg::ctrl_cmd_type    cmd,
   output logic                    load_ready
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_START   = 7'b0000010,
      ST_PIV_RD  = 7'b0000100,
      ST_PIV_CAP = 7'b0001000,
      ST_SWEEP   = 7'b0010000,
      ST_DECIDE  = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_fire) begin
               cmd.load = 1'b1;
               if (status.req_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.scan_first = 1'b1;
            if (status.keep_zero) begin
               cmd.clear_vec = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.keep_all) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PIV_RD;
            end
         end
         ST_PIV_RD: begin
            cmd.rd_pivot = 1'b1;
            state_in     = ST_PIV_CAP;
         end
         ST_PIV_CAP: begin
            cmd.cap_pivot = 1'b1;
            state_in      = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.last_cmp) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.keep_hit) begin
               state_in = ST_EMIT;
            end else if (status.last_scan) begin
               cmd.clear_vec = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_PIV_RD;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_scan) begin
                  cmd.clear_vec = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in      = status.keep_all ? ST_EMIT : ST_PIV_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign load_ready = (state_ff == ST_IDLE);

endmodule

/* rtl/tks_dpath.sv */
// ----------------------------------------------------------------------------
// tks_dpath
// Datapath of the top-k selector: score memory, load and scan counters,
// pivot compare with rank counter, and the result register.
// ----------------------------------------------------------------------------
module tks_dpath #(
   parameter int MAX_ENTRIES = 64,
   parameter int SCORE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tks_pkg::ctrl_cmd_type                cmd,
   output tks_pkg::ctrl_status_type             status,
   input  logic [tks_pkg::KEEP_COUNT_BITS-1:0]  keep_count,
   input  logic                                 req_valid,
   input  logic                                 load_ready,
   input  tks_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tks_pkg::rsp_payload_type             rsp_payload
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > tks_pkg::KEEP_COUNT_BITS) ? CNT_W : tks_pkg::KEEP_COUNT_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

   logic [CNT_W-1:0]      loaded_ff,  loaded_in;
   logic [IDX_W-1:0]      scan_ff,    scan_in;
   logic [IDX_W-1:0]      cmp_ff,     cmp_in;
   logic [CNT_W-1:0]      rank_ff,    rank_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic [SCORE_BITS-1:0] pivot_ff,   pivot_in;
   logic                  out_valid_ff, out_valid_in;
   tks_pkg::rsp_payload_type out_ff,  out_in;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [SCORE_BITS-1:0] mem_rd_data;
   logic                  outranks;
   logic                  store_full;
   logic [CMP_W-1:0]      keep_ext;
   logic [CMP_W-1:0]      loaded_ext;
   logic [CMP_W-1:0]      total_keep;

   assign store_full = (loaded_ff == FULL_COUNT);
   assign mem_wr_en  = cmd.load && !store_full;

   always_comb begin
      if (cmd.cap_pivot) begin
         mem_rd_addr = '0;
      end else if (cmd.sweep) begin
         mem_rd_addr = cmp_ff + IDX_W'(1);
      end else begin
         mem_rd_addr = scan_ff;
      end
   end

   tks_ram #(
      .WIDTH (SCORE_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_W'(loaded_ff)),
      .wr_data (SCORE_BITS'(req_payload.score)),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // entry cmp outranks the pivot: higher score, or equal score at a lower index
   assign outranks = (mem_rd_data > pivot_ff) ||
                     ((mem_rd_data == pivot_ff) && (cmp_ff < scan_ff));

   assign keep_ext   = CMP_W'(keep_count);
   assign loaded_ext = CMP_W'(loaded_ff);
   // ranking is a strict order, so exactly this many indices are kept
   assign total_keep = status.keep_all ? loaded_ext : keep_ext;

   always_comb begin
      loaded_in    = loaded_ff;
      scan_in      = scan_ff;
      cmp_in       = cmp_ff;
      rank_in      = rank_ff;
      emitted_in   = emitted_ff;
      pivot_in     = pivot_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (mem_wr_en) begin
         loaded_in = loaded_ff + CNT_W'(1);
      end
      if (cmd.scan_first) begin
         scan_in    = '0;
         emitted_in = '0;
      end
      if (cmd.scan_next) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      if (cmd.cap_pivot) begin
         pivot_in = mem_rd_data;
         cmp_in   = '0;
         rank_in  = '0;
      end
      if (cmd.sweep) begin
         cmp_in = cmp_ff + IDX_W'(1);
         if (outranks) begin
            rank_in = rank_ff + CNT_W'(1);
         end
      end
      if (cmd.emit) begin
         out_valid_in      = 1'b1;
         out_in.kept_index = tks_pkg::KEPT_INDEX_BITS'(scan_ff);
         out_in.last_kept  = ((CMP_W'(emitted_ff) + CMP_W'(1)) == total_keep);
         emitted_in        = emitted_ff + CNT_W'(1);
      end
      if (cmd.clear_vec) begin
         loaded_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         scan_ff      <= '0;
         cmp_ff       <= '0;
         rank_ff      <= '0;
         emitted_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         scan_ff      <= scan_in;
         cmp_ff       <= cmp_in;
         rank_ff      <= rank_in;
         emitted_ff   <= emitted_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
      out_ff   <= out_in;
   end

   always_comb begin
      status.req_fire  = req_valid && load_ready;
      status.req_last  = req_payload.last_score;
      status.keep_zero = (keep_count == '0);
      status.keep_all  = (keep_ext >= loaded_ext);
      status.keep_hit  = (CMP_W'(rank_ff) < keep_ext);
      status.last_scan = ((CNT_W'(scan_ff) + CNT_W'(1)) == loaded_ff);
      status.last_cmp  = ((CNT_W'(cmp_ff) + CNT_W'(1)) == loaded_ff);
      status.out_free  = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* rtl/top_k_index_select.sv */
// ----------------------------------------------------------------------------
// top_k_index_select
// Loads a vector of unsigned Q16.16 scores and returns, in ascending order,
// the indices of the keep_count highest scores (ties: lower index wins).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req_    | in        | req_valid/req_stall  | score, last_score
//   rsp_    | out       | rsp_valid/rsp_stall  | kept_index, last_kept
//   csr_    | in/out    | APB, pready tied high| keep_count at byte address 0
//
// Scores load one beat per cycle while req_stall is low. After the last beat
// of a vector, req_stall stays high while the block ranks it: nothing is kept
// when keep_count is 0, every index is emitted unswept when keep_count is at
// least the vector length, else each index is swept through the single RAM
// read port. rsp_stall keeps it high longer. Synchronous active-high reset;
// keep_count resets to 64.
// ----------------------------------------------------------------------------
module top_k_index_select #(
   parameter int MAX_ENTRIES = 64,
   parameter int SCORE_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tks_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tks_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tks_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [tks_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [tks_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic [tks_pkg::KEEP_COUNT_BITS-1:0] keep_count_ff, keep_count_in;
   logic [tks_pkg::CSR_REG_BITS-1:0]    csr_reg;
   logic                                csr_write;
   logic                                load_ready;
   tks_pkg::ctrl_cmd_type               cmd;
   tks_pkg::ctrl_status_type            status;

   assign csr_pready = 1'b1;
   assign csr_reg    = csr_paddr[tks_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      keep_count_in = keep_count_ff;
      if (csr_write && (csr_reg == tks_pkg::REG_KEEP_COUNT)) begin
         keep_count_in = csr_pwdata[tks_pkg::KEEP_COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= tks_pkg::KEEP_COUNT_RESET;
      end else begin
         keep_count_ff <= keep_count_in;
      end
   end

   always_comb begin
      if (csr_reg == tks_pkg::REG_KEEP_COUNT) begin
         csr_prdata = tks_pkg::CSR_DATA_BITS'(keep_count_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign req_stall = !load_ready;

   tks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .cmd        (cmd),
      .load_ready (load_ready)
   );

   tks_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SCORE_BITS  (SCORE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .keep_count  (keep_count_ff),
      .req_valid   (req_valid),
      .load_ready  (load_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for top_k_index_select. Score vectors go in on the req_
// channel, keep_count is set through the APB port between phases, and every
// kept index beat on the rsp_ channel is compared field by field with an
// in-bench ranking of the same vector. Both channels idle in random bursts,
// and the output is held off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_ENTRIES   = 64;
   // settle wait that outlasts a full-store ranking pass
   localparam int SETTLE_CYCLES = 4500;
   localparam logic [tks_pkg::CSR_ADDR_BITS-1:0] KEEP_COUNT_ADDR =
      {tks_pkg::REG_KEEP_COUNT, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   tks_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   tks_pkg::rsp_payload_type rsp_payload;

   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [tks_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [tks_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [tks_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   // predictor state
   logic [tks_pkg::SCORE_FIELD_BITS-1:0] loaded_scores[$];
   logic [tks_pkg::KEEP_COUNT_BITS-1:0]  keep_setting = tks_pkg::KEEP_COUNT_RESET;
   tks_pkg::rsp_payload_type             expected_kept[$];

   int  fail_count = 0;
   int  csr_fail_count = 0;
   int  items_sent = 0;
   bit  tx_idle_en = 1'b1;
   bit  rx_idle_en = 1'b1;
   int  hold_req   = 0;
   int  hold_seen  = 0;

   int  hold_left  = 0;
   int  stall_left = 0;
   int  quiet_left = 0;

   top_k_index_select #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .SCORE_BITS (tks_pkg::SCORE_FIELD_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   task automatic select_kept();
      int unsigned              n;
      int unsigned              outrank;
      int unsigned              kept_idx[$];
      tks_pkg::rsp_payload_type beat;
      n = loaded_scores.size();
      for (int i = 0; i < n; i++) begin
         if (keep_setting >= n) begin
            kept_idx.insert(kept_idx.size(), i);
         end else begin
            outrank = 0;
            for (int j = 0; j < n; j++) begin
               if (loaded_scores[j] > loaded_scores[i] ||
                   (loaded_scores[j] == loaded_scores[i] && j < i))
                  outrank++;
            end
            if (outrank < keep_setting)
               kept_idx.insert(kept_idx.size(), i);
         end
      end
      foreach (kept_idx[k]) begin
         beat.kept_index = tks_pkg::KEPT_INDEX_BITS'(kept_idx[k]);
         beat.last_kept  = (k == kept_idx.size() - 1);
         expected_kept.insert(expected_kept.size(), beat);
      end
      loaded_scores.delete();
   endtask

   task automatic load_score(input tks_pkg::req_payload_type beat);
      // store saturates; a marked beat still closes the vector
      if (loaded_scores.size() < MAX_ENTRIES)
         loaded_scores.insert(loaded_scores.size(), beat.score);
      if (beat.last_score)
         select_kept();
   endtask

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      tks_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_kept.size() == 0) begin
            $display("%0t: unexpected kept beat: expected none, actual index %0d last %0b",
                     $time, rsp_payload.kept_index, rsp_payload.last_kept);
            fail_count++;
         end else begin
            want = expected_kept.pop_front();
            if (rsp_payload.kept_index !== want.kept_index) begin
               $display("%0t: kept_index wrong: expected %0d, actual %0d",
                        $time, want.kept_index, rsp_payload.kept_index);
               fail_count++;
            end
            if (rsp_payload.last_kept !== want.last_kept) begin
               $display("%0t: last_kept wrong: expected %0b, actual %0b",
                        $time, want.last_kept, rsp_payload.last_kept);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // output stall: random bursts, quiet stretches, and the long hold
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      int pick;
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = $urandom_range(600, 900);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rx_idle_en || quiet_left > 0) begin
         if (quiet_left > 0)
            quiet_left--;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         pick = $urandom_range(0, 39);
         if (pick < 4) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall  <= 1'b1;
         end else begin
            if (pick == 4)
               quiet_left = $urandom_range(50, 200);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_score(input logic [tks_pkg::SCORE_FIELD_BITS-1:0] score,
                             input logic last);
      tks_pkg::req_payload_type beat;
      int                       gap;
      beat.score      = score;
      beat.last_score = last;
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      load_score(beat);
      items_sent++;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // always waits on the clock so valid is never dropped and raised in one step
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_kept.size() != 0);
   endtask

   task automatic check_keep_count();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= KEEP_COUNT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[tks_pkg::KEEP_COUNT_BITS-1:0] !== keep_setting) begin
         $display("%0t: keep_count readback wrong: expected %0d, actual %0d",
                  $time, keep_setting, csr_prdata[tks_pkg::KEEP_COUNT_BITS-1:0]);
         csr_fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // only while idle: all results in, and any silent ranking pass finished
   task automatic write_keep_count(input int unsigned value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= KEEP_COUNT_ADDR;
      csr_pwdata  <= tks_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      keep_setting = tks_pkg::KEEP_COUNT_BITS'(value);
      @(posedge clock);
      check_keep_count();
   endtask

   function automatic logic [tks_pkg::SCORE_FIELD_BITS-1:0] pick_score(input bit tie_heavy);
      if (tie_heavy)
         return ($urandom_range(0, 7) == 0) ?
                '1 : tks_pkg::SCORE_FIELD_BITS'($urandom_range(0, 3));
      return $urandom;
   endfunction

   task automatic send_vector(input int len, input bit tie_heavy);
      for (int i = 0; i < len; i++)
         send_score(pick_score(tie_heavy), i == len - 1);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_value();
      check_keep_count();
      // reset keep_count keeps everything
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'h0000_0000, 1'b0);
      send_score(32'hAAAA_AAAA, 1'b0);
      send_score(32'h5555_5555, 1'b1);
   endtask

   task automatic test_directed_ranking();
      write_keep_count(1);
      send_score(32'h0000_0000, 1'b0);
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'hFFFF_FFFF, 1'b1);
      send_score(32'hFFFF_FFFF, 1'b1);          // one-entry vector
      send_score(32'd5, 1'b0);
      send_score(32'd9, 1'b0);
      send_score(32'd9, 1'b0);
      send_score(32'd3, 1'b1);

      write_keep_count(2);
      repeat (3) send_score(32'd7, 1'b0);       // all tied: lowest indices win
      send_score(32'd7, 1'b1);

      write_keep_count(0);                      // vector consumed, nothing out
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'd1, 1'b1);

      write_keep_count(127);
      send_score(32'h0000_0000, 1'b1);
      send_score(32'h0001_0000, 1'b0);
      send_score(32'h0000_FFFF, 1'b1);
   endtask

   task automatic test_store_full();
      write_keep_count(3);
      // entries past the store are dropped, including the marked one
      send_score(32'hFFFF_FFFF, 1'b0);
      for (int i = 1; i < MAX_ENTRIES - 1; i++)
         send_score(pick_score(i % 3 == 0), 1'b0);
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'hFFFF_FFFF, 1'b0);
      send_score(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_output_hold();
      write_keep_count(64);
      hold_req++;
      for (int v = 0; v < 5; v++)
         send_vector(10, v[0]);
      wait_drained();
      // second pass with ranking active while backed up
      write_keep_count(4);
      hold_req++;
      repeat (3) send_vector($urandom_range(6, 12), 1'b0);
      wait_drained();
   endtask

   task automatic test_random(input int target);
      int pick;
      int len;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       write_keep_count(0);
            1:       write_keep_count(127);
            2:       write_keep_count(64);
            3:       write_keep_count(1);
            4, 5, 6: write_keep_count($urandom_range(1, 12));
            default: write_keep_count($urandom_range(0, 64));
         endcase
         // some phases run without sender idling
         tx_idle_en = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_ENTRIES)
                                              : $urandom_range(1, 12);
            send_vector(len, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 5) == 0)
               wait_drained();
         end
      end
      tx_idle_en = 1'b1;
   endtask

   task automatic test_full_rate(input int target);
      write_keep_count($urandom_range(2, 8));
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      while (items_sent < target)
         send_vector($urandom_range(1, 12), $urandom_range(0, 1) == 1);
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_directed_ranking();
      test_store_full();
      test_output_hold();
      test_random(320);
      test_full_rate(360);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && csr_fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout, %0d kept beats still due", $time, expected_kept.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
